// File: hdl/assert_macros.svh
// Assertion macros shared by the prefix interning table RTL.
// Needs nothing else; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define PIT_ASSERT_SAME(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pit same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define PIT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pit next-cycle check failed");

`endif

// File: hdl/pit_pkg.sv
// Shared types and constants for the prefix interning table.
// Used by pit_front, pit_fifo, pit_back and prefix_interning_table_top.
`default_nettype none

package pit_pkg;

  localparam int LEN_W     = 6;
  localparam int ADDR_W    = 32;
  localparam int QID_W     = 16;
  localparam int RID_W     = 16;
  localparam int STATUS_W  = 3;
  // Widest slot key: marker bit over the longest supported prefix
  localparam int KEY_MAX_W = 25;

  typedef enum logic [STATUS_W-1:0] {
    ST_EXISTING = 3'd0,
    ST_NEW      = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_FULL     = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_INTERN,
    OP_REVERSE,
    OP_TOO_LONG
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [KEY_MAX_W-1:0] key;
    logic [QID_W-1:0]     qid;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC,
    BK_SHIFT
  } bk_state_t;

endpackage

`default_nettype wire

// File: hdl/prefix_interning_table_top.sv
// Top level of the prefix interning table: front end, queue, back end.
// Depends on pit_pkg, pit_front, pit_fifo, pit_back and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Interns IPv4 prefixes into dense ids and maps ids back to prefixes.
// After reset the slot memory is swept clear, one entry a cycle, over all
// 2^(MAX_LEN+1) entries (131072 at the default MAX_LEN); in_ready stays low
// for that time. The back end works on one word at a time on single-port
// memories with registered reads: an intern word is a slot read, then a
// decision that writes both memories for a new prefix; a too-long word is
// taken, then answered; a reverse word is a key read, then the marker search
// or the unknown result, then the alignment shift. A two-entry queue keeps
// taking input words while a result waits in the output register.
module prefix_interning_table_top #(
  parameter int MAX_LEN = 16,
  parameter int ID_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_kind,
  input  wire logic [pit_pkg::LEN_W-1:0]       in_prefix_len,
  input  wire logic [pit_pkg::ADDR_W-1:0]      in_address,
  input  wire logic [pit_pkg::QID_W-1:0]       in_query_id,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [pit_pkg::STATUS_W-1:0]         out_status,
  output logic [pit_pkg::RID_W-1:0]            out_result_id,
  output logic [pit_pkg::LEN_W-1:0]            out_result_len,
  output logic [pit_pkg::ADDR_W-1:0]           out_result_address
);

  logic          push, pop, fifo_full, fifo_empty, clearing;
  pit_pkg::cmd_t push_cmd, head;

  pit_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_prefix_len (in_prefix_len),
    .in_address    (in_address),
    .in_query_id   (in_query_id),
    .fifo_full     (fifo_full),
    .clearing      (clearing),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  pit_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .head     (head),
    .empty    (fifo_empty)
  );

  pit_back #(
    .MAX_LEN (MAX_LEN),
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .fifo_empty         (fifo_empty),
    .pop                (pop),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_result_id      (out_result_id),
    .out_result_len     (out_result_len),
    .out_result_address (out_result_address)
  );

  // Queue never overflows or underflows; no traffic during the clearing sweep
  `PIT_ASSERT_SAME(a_no_push_full, clk, rst_n, push, !fifo_full)
  `PIT_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop, !fifo_empty)
  `PIT_ASSERT_SAME(a_clear_quiet, clk, rst_n, clearing, !in_ready && !out_valid && !pop)
  `PIT_ASSERT_NEXT(a_pop_busy, clk, rst_n, pop, !pop)

endmodule

`default_nettype wire

// File: hdl/pit_front.sv
// Front end: accepts input words, classifies them and builds slot keys.
// Depends on pit_pkg; feeds the command queue (pit_fifo).
`default_nettype none

module pit_front #(
  parameter int MAX_LEN = 16
) (
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_kind,
  input  wire logic [pit_pkg::LEN_W-1:0]   in_prefix_len,
  input  wire logic [pit_pkg::ADDR_W-1:0]  in_address,
  input  wire logic [pit_pkg::QID_W-1:0]   in_query_id,
  input  wire logic                        fifo_full,
  input  wire logic                        clearing,
  output logic                             push,
  output pit_pkg::cmd_t                    push_cmd
);

  logic [pit_pkg::LEN_W-1:0]  shamt;
  logic [pit_pkg::ADDR_W:0]   marked;
  logic                       too_long;

  // Take a word only when the queue has room and the slot store is usable
  assign in_ready = !fifo_full && !clearing;
  assign push     = in_valid && in_ready;

  // Build the key: marker 1 above the top prefix_len bits of the address
  assign too_long = in_prefix_len > pit_pkg::LEN_W'(MAX_LEN);
  assign shamt    = pit_pkg::LEN_W'(pit_pkg::ADDR_W) - in_prefix_len;
  assign marked   = {1'b1, in_address} >> shamt;

  // Classify the word
  always_comb begin
    push_cmd.key = marked[pit_pkg::KEY_MAX_W-1:0];
    push_cmd.qid = in_query_id;
    if (in_kind) begin
      push_cmd.op = pit_pkg::OP_REVERSE;
    end else if (too_long) begin
      push_cmd.op = pit_pkg::OP_TOO_LONG;
    end else begin
      push_cmd.op = pit_pkg::OP_INTERN;
    end
  end

endmodule

`default_nettype wire

// File: hdl/pit_fifo.sv
// Two-entry command queue between the front end and the back end.
// Depends on pit_pkg for the command type.
`default_nettype none

module pit_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pit_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output pit_pkg::cmd_t      head,
  output logic               empty
);

  localparam int DEPTH = 2;

  pit_pkg::cmd_t entry_r [DEPTH];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full  = count_r == 2'(DEPTH);
  assign empty = count_r == 2'd0;
  assign head  = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: hdl/pit_back.sv
// Back end: slot and key memories, id counter, result register.
// Depends on pit_pkg; drains the command queue (pit_fifo).
`default_nettype none

module pit_back #(
  parameter int MAX_LEN = 16,
  parameter int ID_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pit_pkg::cmd_t                 head,
  input  wire logic                          fifo_empty,
  output logic                               pop,
  output logic                               clearing,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pit_pkg::STATUS_W-1:0]       out_status,
  output logic [pit_pkg::RID_W-1:0]          out_result_id,
  output logic [pit_pkg::LEN_W-1:0]          out_result_len,
  output logic [pit_pkg::ADDR_W-1:0]         out_result_address
);

  localparam int KEY_W      = MAX_LEN + 1;
  localparam int SLOT_DEPTH = 1 << KEY_W;
  localparam int ID_DEPTH   = 1 << ID_BITS;
  localparam int CNT_W      = ID_BITS + 1;
  localparam int CMP_W      = (CNT_W > pit_pkg::QID_W) ? CNT_W : pit_pkg::QID_W;
  localparam int SLOT_W     = ID_BITS + 1;

  pit_pkg::bk_state_t state_r, state_nxt;

  // Memories: slot entry is {valid, id}; key store holds slot keys per id
  logic [SLOT_W-1:0] slot_mem [SLOT_DEPTH];
  logic [KEY_W-1:0]  key_mem  [ID_DEPTH];

  logic              slot_we, slot_re;
  logic [KEY_W-1:0]  slot_waddr;
  logic [SLOT_W-1:0] slot_wdata;
  logic [SLOT_W-1:0] slot_rdata_r;
  logic              key_we, key_re;
  logic [KEY_W-1:0]  key_rdata_r;

  logic [KEY_W-1:0]  clr_cnt_r;
  logic              clr_inc;
  logic [CNT_W-1:0]  next_id_r;
  logic              nid_inc;
  pit_pkg::cmd_t     cur_r;
  logic              cur_ld;
  logic [pit_pkg::LEN_W-1:0] top_r, top_nxt;
  logic              top_ld;

  logic                         out_valid_r;
  pit_pkg::status_t             out_status_r, out_status_nxt;
  logic [pit_pkg::RID_W-1:0]    out_id_r, out_id_nxt;
  logic [pit_pkg::LEN_W-1:0]    out_len_r, out_len_nxt;
  logic [pit_pkg::ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic                         out_ld;

  logic                   out_free;
  logic [KEY_W-1:0]       head_key, cur_key;
  logic [CMP_W-1:0]       head_qid_ext, cur_qid_ext, nid_ext, hit_id_ext;
  logic                   unknown, id_full, slot_hit;
  logic [pit_pkg::LEN_W-1:0] shamt;
  logic [pit_pkg::ADDR_W:0]  rev_wide;

  assign out_free     = !out_valid_r || out_ready;
  assign head_key     = head.key[KEY_W-1:0];
  assign cur_key      = cur_r.key[KEY_W-1:0];
  assign head_qid_ext = CMP_W'(head.qid);
  assign cur_qid_ext  = CMP_W'(cur_r.qid);
  assign nid_ext      = CMP_W'(next_id_r);
  assign hit_id_ext   = CMP_W'(slot_rdata_r[ID_BITS-1:0]);
  assign unknown      = cur_qid_ext >= nid_ext;
  assign id_full      = next_id_r[ID_BITS];
  assign slot_hit     = slot_rdata_r[ID_BITS];
  assign clearing     = state_r == pit_pkg::BK_CLEAR;

  // Find the marker bit: its position is the prefix length
  always_comb begin
    top_nxt = '0;
    for (int i = 0; i < KEY_W; i++) begin
      if (key_rdata_r[i]) begin
        top_nxt = pit_pkg::LEN_W'(i);
      end
    end
  end

  // Shift the stored key so the prefix bits sit at the top of the address
  assign shamt    = pit_pkg::LEN_W'(pit_pkg::ADDR_W) - top_r;
  assign rev_wide = (pit_pkg::ADDR_W + 1)'(key_rdata_r) << shamt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pit_pkg::BK_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = pit_pkg::BK_IDLE;
        end
      end
      pit_pkg::BK_IDLE: begin
        if (!fifo_empty) begin
          state_nxt = pit_pkg::BK_EXEC;
        end
      end
      pit_pkg::BK_EXEC: begin
        if (cur_r.op == pit_pkg::OP_REVERSE && !unknown) begin
          state_nxt = pit_pkg::BK_SHIFT;
        end else if (out_free) begin
          state_nxt = pit_pkg::BK_IDLE;
        end
      end
      pit_pkg::BK_SHIFT: begin
        if (out_free) begin
          state_nxt = pit_pkg::BK_IDLE;
        end
      end
      default: state_nxt = pit_pkg::BK_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop            = 1'b0;
    cur_ld         = 1'b0;
    slot_we        = 1'b0;
    slot_re        = 1'b0;
    slot_waddr     = cur_key;
    slot_wdata     = {1'b1, next_id_r[ID_BITS-1:0]};
    key_we         = 1'b0;
    key_re         = 1'b0;
    clr_inc        = 1'b0;
    nid_inc        = 1'b0;
    top_ld         = 1'b0;
    out_ld         = 1'b0;
    out_status_nxt = pit_pkg::ST_EXISTING;
    out_id_nxt     = '0;
    out_len_nxt    = '0;
    out_addr_nxt   = '0;
    unique case (state_r)
      pit_pkg::BK_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_cnt_r;
        slot_wdata = '0;
        clr_inc    = 1'b1;
      end
      pit_pkg::BK_IDLE: begin
        if (!fifo_empty) begin
          pop     = 1'b1;
          cur_ld  = 1'b1;
          slot_re = head.op == pit_pkg::OP_INTERN;
          key_re  = head.op == pit_pkg::OP_REVERSE;
        end
      end
      pit_pkg::BK_EXEC: begin
        case (cur_r.op)
          pit_pkg::OP_TOO_LONG: begin
            out_ld         = out_free;
            out_status_nxt = pit_pkg::ST_TOO_LONG;
          end
          pit_pkg::OP_INTERN: begin
            out_ld = out_free;
            if (slot_hit) begin
              out_status_nxt = pit_pkg::ST_EXISTING;
              out_id_nxt     = hit_id_ext[pit_pkg::RID_W-1:0];
            end else if (id_full) begin
              out_status_nxt = pit_pkg::ST_FULL;
            end else begin
              out_status_nxt = pit_pkg::ST_NEW;
              out_id_nxt     = nid_ext[pit_pkg::RID_W-1:0];
              slot_we        = out_free;
              key_we         = out_free;
              nid_inc        = out_free;
            end
          end
          pit_pkg::OP_REVERSE: begin
            if (unknown) begin
              out_ld         = out_free;
              out_status_nxt = pit_pkg::ST_UNKNOWN;
            end else begin
              top_ld = 1'b1;
            end
          end
          default: ;
        endcase
      end
      pit_pkg::BK_SHIFT: begin
        out_ld         = out_free;
        out_status_nxt = pit_pkg::ST_EXISTING;
        out_len_nxt    = top_r;
        out_addr_nxt   = rev_wide[pit_pkg::ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pit_pkg::BK_CLEAR;
      clr_cnt_r   <= '0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_inc) begin
        clr_cnt_r <= clr_cnt_r + KEY_W'(1);
      end
      if (nid_inc) begin
        next_id_r <= next_id_r + CNT_W'(1);
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the word in work, the found length and the result
  always_ff @(posedge clk) begin
    if (cur_ld) begin
      cur_r <= head;
    end
    if (top_ld) begin
      top_r <= top_nxt;
    end
    if (out_ld) begin
      out_status_r <= out_status_nxt;
      out_id_r     <= out_id_nxt;
      out_len_r    <= out_len_nxt;
      out_addr_r   <= out_addr_nxt;
    end
  end

  // Slot memory: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_re) begin
      slot_rdata_r <= slot_mem[head_key];
    end
  end

  // Key memory: written with the new id, read for reverse lookups
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[next_id_r[ID_BITS-1:0]] <= cur_key;
    end
  end

  always_ff @(posedge clk) begin
    if (key_re) begin
      key_rdata_r <= key_mem[head_qid_ext[ID_BITS-1:0]];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_id      = out_id_r;
  assign out_result_len     = out_len_r;
  assign out_result_address = out_addr_r;

endmodule

`default_nettype wire
